@@ design/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with reverse.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Queue commands as carried in the low bits of the input request.
	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_REVERSE    = 2'd3
	} cmd_t;

	// Word width of the stored entries.
	localparam int unsigned WORD_W = 32;

	// Input request: command then entry value, padded to whole bytes.
	localparam int unsigned IN_BITS = 2 + WORD_W;
	localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

	// Access strobes from the queue control to the ring store.
	typedef struct packed {
		logic we;
		logic re;
	} mem_req_t;

endpackage

@@ design/deq_mem.sv @@
// ----------------------------------------------------------------------------
// deq_mem
// Ring store: synchronous memory with one write or one registered read.
// ----------------------------------------------------------------------------
module deq_mem
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic              clk,
	input  mem_req_t          req,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Front index, element count and direction flag of the queue. Decodes each
// request into at most one store access and the next index, count and flag.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4,
	parameter int unsigned CW    = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  cmd_t              cmd,
	input  logic [WORD_W-1:0] value,
	output logic              ok,
	output logic              removed,
	output logic [CW-1:0]     count_next,
	output mem_req_t          mem_req,
	output logic [AW-1:0]     mem_addr,
	output logic [WORD_W-1:0] mem_wdata
);

	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	logic          full;
	logic          empty;
	logic [AW-1:0] step;
	logic          back;
	logic [AW:0]   sum;
	logic [AW:0]   dif;
	logic [AW-1:0] moved;
	logic [AW-1:0] front_next;
	logic          rev_next;

	assign full  = (count_q >= DEPTH_C);
	assign empty = (count_q == '0);

	// Offset and direction of the one index move that the command needs.
	always_comb begin
		step = AW'(1);
		back = rev_q;
		case (cmd)
			CMD_PUSH_FRONT: begin
				step = AW'(1);
				back = ~rev_q;
			end
			CMD_PUSH_BACK: begin
				step = count_q[AW-1:0];
				back = rev_q;
			end
			CMD_POP_FRONT: begin
				step = AW'(1);
				back = rev_q;
			end
			CMD_REVERSE: begin
				step = AW'(count_q - CW'(1));
				back = rev_q;
			end
			default: begin
				step = AW'(1);
				back = rev_q;
			end
		endcase
	end

	// Modulo-DEPTH move: both operands are below DEPTH, so one correction does.
	assign sum   = {1'b0, front_q} + {1'b0, step};
	assign dif   = {1'b0, front_q} + DEPTH_X - {1'b0, step};
	always_comb begin
		if (back) begin
			moved = (dif >= DEPTH_X) ? AW'(dif - DEPTH_X) : dif[AW-1:0];
		end else begin
			moved = (sum >= DEPTH_X) ? AW'(sum - DEPTH_X) : sum[AW-1:0];
		end
	end

	always_comb begin
		ok         = 1'b1;
		removed    = 1'b0;
		count_next = count_q;
		front_next = front_q;
		rev_next   = rev_q;
		mem_req    = '0;
		mem_addr   = front_q;
		mem_wdata  = value;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					ok = 1'b0;
				end else begin
					front_next = moved;
					count_next = count_q + CW'(1);
					mem_req.we = acc;
					mem_addr   = moved;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					ok = 1'b0;
				end else begin
					count_next = count_q + CW'(1);
					mem_req.we = acc;
					mem_addr   = moved;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					ok = 1'b0;
				end else begin
					removed    = 1'b1;
					front_next = moved;
					count_next = count_q - CW'(1);
					mem_req.re = acc;
					mem_addr   = front_q;
				end
			end
			CMD_REVERSE: begin
				if (!empty) begin
					front_next = moved;
					rev_next   = ~rev_q;
				end
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (acc) begin
			front_q <= front_next;
			count_q <= count_next;
			rev_q   <= rev_next;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count exceeds the store depth");

	a_refused_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK))
		|=> ($stable(count_q) && $stable(front_q) && $stable(rev_q)))
		else $error("refused insert changed the queue state");

	a_reverse_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !empty && cmd == CMD_REVERSE) |=> (rev_q != $past(rev_q)))
		else $error("reverse of a non-empty queue did not flip the direction");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("store written and read in the same cycle");

endmodule

@@ design/deque_with_reverse.sv @@
// ----------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended queue of 32-bit words with reverse, kept in a ring store.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless the output stalls; each request
// makes at most one store access; the store's read register feeds the output.
// Reset: arst_n clears the front index, count, direction and output valid.
// The store itself is not cleared; no entry is read before it is written.
module deque_with_reverse
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW    = $clog2(DEPTH + 1),
	localparam int unsigned OUT_W = ((1 + WORD_W + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// command [1:0], entry_value [33:2], zero fill above
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// ok [0], removed_value [32:1], element_count above, zero fill on top
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic              acc;
	cmd_t              cmd;
	logic [WORD_W-1:0] value;
	logic              ok;
	logic              removed;
	logic [CW-1:0]     count_next;
	mem_req_t          mem_req;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	logic              valid_q;
	logic              ok_q;
	logic              removed_q;
	logic [CW-1:0]     count_q;

	// A new request may enter when no result is held or the held result leaves in the same cycle.
	assign s_axis_tready = !valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tdata[1:0]);
	assign value         = s_axis_tdata[WORD_W+1:2];

	deq_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.value     (value),
		.ok        (ok),
		.removed   (removed),
		.count_next(count_next),
		.mem_req   (mem_req),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	deq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q      <= ok;
			removed_q <= removed;
			count_q   <= count_next;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = OUT_W'({count_q, (removed_q ? mem_rdata : '0), ok_q});

endmodule
